// ===== hdl/dialogue_phrase_classifier_defines.svh =====
// assertion macros for the dialogue phrase classifier
`ifndef DIALOGUE_PHRASE_CLASSIFIER_DEFINES_SVH
`define DIALOGUE_PHRASE_CLASSIFIER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define DPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dpc_pkg.sv =====
// constants and phrase texts for the dialogue phrase classifier
`default_nettype none
package dpc_pkg;

   localparam int WINDOW_DEPTH = 25;
   localparam int BYTE_W       = 8;
   localparam int WINDOW_W     = WINDOW_DEPTH * BYTE_W;

   localparam int PLAN_LEN   = 26;
   localparam int TYPE_LEN   = 15;
   localparam int DOWANT_LEN = 23;
   localparam int NOASK_LEN  = 15;

   localparam logic [PLAN_LEN*BYTE_W-1:0]   PLAN_TEXT   = "Would you like to proceed?";
   localparam logic [TYPE_LEN*BYTE_W-1:0]   TYPE_TEXT   = "Type something.";
   localparam logic [DOWANT_LEN*BYTE_W-1:0] DOWANT_TEXT = "Do you want to proceed?";
   localparam logic [NOASK_LEN*BYTE_W-1:0]  NOASK_TEXT  = "don't ask again";

   localparam int PH_PLAN   = 0;
   localparam int PH_TYPE   = 1;
   localparam int PH_DOWANT = 2;
   localparam int PH_NOASK  = 3;
   localparam int PH_COUNT  = 4;

   typedef logic [1:0] line_phase_type;
   localparam line_phase_type LP_LEAD   = 2'd0;
   localparam line_phase_type LP_PREFIX = 2'd1;
   localparam line_phase_type LP_DIGIT  = 2'd2;
   localparam line_phase_type LP_REST   = 2'd3;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_NONE    = 3'd0;
   localparam kind_type KIND_PLAN    = 3'd1;
   localparam kind_type KIND_ASK     = 3'd2;
   localparam kind_type KIND_PERMIT  = 3'd3;
   localparam kind_type KIND_PROCEED = 3'd4;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_DIGIT_LO = 8'h31;
   localparam logic [7:0] CH_DIGIT_HI = 8'h34;

endpackage
`default_nettype wire

// ===== hdl/dialogue_phrase_classifier.sv =====
// dialogue phrase classifier: byte-stream phrase scan and end-of-capture classification
// one result beat appears in the cycle after the final byte is accepted
// throughput: one text byte per cycle while req_ready is high, set by a single pass of window compares
// input is taken whenever the result register is empty or being drained
// reset clears the history window, phrase flags, line recogniser and result valid
`default_nettype none
`include "dialogue_phrase_classifier_defines.svh"
module dialogue_phrase_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_final_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_dialogue_kind,
   output logic [1:0]      rsp_reply_choice,
   output logic [2:0]      rsp_settle_seconds
);
   import dpc_pkg::*;

   logic [WINDOW_W-1:0]        window_ff, window_in;
   logic [PH_COUNT-1:0]        phrase_seen_ff, phrase_seen_in, phrase_hit;
   logic                       option_seen_ff, option_seen_in;
   line_phase_type             phase_ff, phase_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   kind_type                   kind_ff, kind_in;
   logic [1:0]                 choice_ff, choice_in;
   logic [2:0]                 settle_ff, settle_in;

   logic                       req_beat, last_beat;
   logic [WINDOW_W+BYTE_W-1:0] view;
   logic                       is_blank, is_digit;
   logic [PH_COUNT-1:0]        flags_now;
   logic                       option_now;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;
   assign last_beat = req_beat && req_final_byte;

   // newest byte sits in the low bits
   assign view = {window_ff, req_text_byte};

   always_comb begin
      phrase_hit            = '0;
      phrase_hit[PH_PLAN]   = (view[PLAN_LEN*BYTE_W-1:0] == PLAN_TEXT);
      phrase_hit[PH_TYPE]   = (view[TYPE_LEN*BYTE_W-1:0] == TYPE_TEXT);
      phrase_hit[PH_DOWANT] = (view[DOWANT_LEN*BYTE_W-1:0] == DOWANT_TEXT);
      phrase_hit[PH_NOASK]  = (view[NOASK_LEN*BYTE_W-1:0] == NOASK_TEXT);
   end

   assign is_blank = (req_text_byte == CH_SPACE) || (req_text_byte == CH_TAB);
   assign is_digit = (req_text_byte >= CH_DIGIT_LO) && (req_text_byte <= CH_DIGIT_HI);

   // option line recogniser
   always_comb begin
      option_now = option_seen_ff;
      phase_in   = phase_ff;
      if (req_text_byte == CH_NEWLINE) begin
         phase_in = LP_LEAD;
      end else begin
         case (phase_ff)
            LP_LEAD: begin
               if (is_blank) phase_in = LP_LEAD;
               else if (req_text_byte == CH_QUERY || req_text_byte == CH_GREATER)
                  phase_in = LP_PREFIX;
               else if (is_digit) phase_in = LP_DIGIT;
               else phase_in = LP_REST;
            end
            LP_PREFIX: begin
               if (is_blank) phase_in = LP_PREFIX;
               else if (is_digit) phase_in = LP_DIGIT;
               else phase_in = LP_REST;
            end
            LP_DIGIT: begin
               if (req_text_byte == CH_PERIOD) option_now = 1'b1;
               phase_in = LP_REST;
            end
            default: begin
               phase_in = LP_REST;
            end
         endcase
      end
   end

   assign flags_now = phrase_seen_ff | phrase_hit;

   // classification in priority order
   always_comb begin
      kind_in   = KIND_NONE;
      choice_in = 2'd0;
      settle_in = 3'd0;
      if (flags_now[PH_PLAN]) begin
         kind_in = KIND_PLAN;    choice_in = 2'd2; settle_in = 3'd5;
      end else if (flags_now[PH_TYPE] && option_now) begin
         kind_in = KIND_ASK;     choice_in = 2'd1; settle_in = 3'd5;
      end else if (flags_now[PH_DOWANT] && flags_now[PH_NOASK]) begin
         kind_in = KIND_PERMIT;  choice_in = 2'd2; settle_in = 3'd2;
      end else if (flags_now[PH_DOWANT]) begin
         kind_in = KIND_PROCEED; choice_in = 2'd1; settle_in = 3'd2;
      end
   end

   always_comb begin
      window_in      = window_ff;
      phrase_seen_in = phrase_seen_ff;
      option_seen_in = option_seen_ff;
      if (last_beat) begin
         window_in      = '0;
         phrase_seen_in = '0;
         option_seen_in = 1'b0;
      end else if (req_beat) begin
         window_in      = view[WINDOW_W-1:0];
         phrase_seen_in = flags_now;
         option_seen_in = option_now;
      end
   end

   assign rsp_valid_in = last_beat || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         phrase_seen_ff <= '0;
         option_seen_ff <= 1'b0;
         phase_ff       <= LP_LEAD;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_ff      <= window_in;
         phrase_seen_ff <= phrase_seen_in;
         option_seen_ff <= option_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (last_beat) phase_ff <= LP_LEAD;
         else if (req_beat) phase_ff <= phase_in;
      end
   end

   // result payload, loaded on the final byte
   always_ff @(posedge clock) begin
      if (last_beat) begin
         kind_ff   <= kind_in;
         choice_ff <= choice_in;
         settle_ff <= settle_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dialogue_kind  = kind_ff;
   assign rsp_reply_choice   = choice_ff;
   assign rsp_settle_seconds = settle_ff;

   `DPC_ASSERT_NEXT(a_final_gives_beat, clock, reset, last_beat, rsp_valid_ff,
      "final byte did not produce a result beat")
   `DPC_ASSERT_NEXT(a_final_clears_state, clock, reset, last_beat,
      phrase_seen_ff == '0 && !option_seen_ff && phase_ff == LP_LEAD,
      "scan state not cleared after final byte")
   `DPC_ASSERT_NOW(a_none_is_zero, clock, reset, rsp_valid_ff && kind_ff == KIND_NONE,
      choice_ff == 2'd0 && settle_ff == 3'd0, "empty class carries option or settle time")
   `DPC_ASSERT_NOW(a_option_after_digit, clock, reset, $rose(option_seen_ff),
      $past(phase_ff) == LP_DIGIT, "option line flagged without a digit before it")

endmodule
`default_nettype wire
